>>> src/vrfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrfe_pkg
// Types and constants shared by the varint record field encoder.
// ----------------------------------------------------------------------------
package vrfe_pkg;

    localparam int FUNC_W     = 3;
    localparam int UVALUE_W   = 64;
    localparam int SVALUE_W   = 32;
    localparam int BYTE_W     = 8;
    localparam int GROUP_W    = 7;
    localparam int COUNT_W    = 4;
    localparam int FMASK_W    = 5;
    localparam int CMD_FIFO_DEPTH = 2;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_U32  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_U64  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_S32  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RAW  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LE64 = 3'd4;

    localparam logic [BYTE_W-1:0] CONT_BIT = 8'h80;

    // group encodings carry a continuation bit, byte encodings shift out raw bytes
    typedef enum logic {
        KIND_GROUP = 1'b0,
        KIND_BYTES = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [GROUP_W-1:0]   first;
        logic [UVALUE_W-1:0]  rest;
        logic [COUNT_W-1:0]   max_bytes;
        logic [FMASK_W-1:0]   final_mask;
    } t_cmd;

endpackage

>>> src/vrfe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrfe_if
// Valid/ready channels for input items and encoded bytes.
// ----------------------------------------------------------------------------
interface vrfe_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [63:0] uvalue;
    logic signed [31:0] svalue;

    modport source (output valid, output func, output uvalue, output svalue, input ready);
    modport sink   (input valid, input func, input uvalue, input svalue, output ready);
endinterface

interface vrfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

>>> src/vrfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrfe_front
// Classifies an input item into an encoding command for the back end.
// ----------------------------------------------------------------------------
module vrfe_front
    import vrfe_pkg::*;
(
    input  logic [FUNC_W-1:0]          i_func,
    input  logic [UVALUE_W-1:0]        i_uvalue,
    input  logic signed [SVALUE_W-1:0] i_svalue,
    output logic                       o_cmd_used,
    output t_cmd                       o_cmd
);

    logic                neg;
    logic [SVALUE_W-1:0] mag;

    // two's complement of the most negative value gives 2^31, as wanted
    assign neg = i_svalue[SVALUE_W-1];
    assign mag = neg ? (~i_svalue + 32'd1) : i_svalue;

    always_comb begin
        o_cmd_used        = 1'b1;
        o_cmd.kind        = KIND_GROUP;
        o_cmd.first       = i_uvalue[GROUP_W-1:0];
        o_cmd.rest        = '0;
        o_cmd.max_bytes   = 4'd1;
        o_cmd.final_mask  = 5'h0f;
        unique case (i_func)
            FUNC_U32: begin
                o_cmd.rest       = {39'd0, i_uvalue[31:7]};
                o_cmd.max_bytes  = 4'd5;
                o_cmd.final_mask = 5'h0f;
            end
            FUNC_U64: begin
                o_cmd.rest       = {7'd0, i_uvalue[63:7]};
                o_cmd.max_bytes  = 4'd10;
                o_cmd.final_mask = 5'h01;
            end
            FUNC_S32: begin
                o_cmd.first      = {mag[5:0], neg};
                o_cmd.rest       = {38'd0, mag[31:6]};
                o_cmd.max_bytes  = 4'd5;
                o_cmd.final_mask = 5'h1f;
            end
            FUNC_RAW: begin
                o_cmd.kind       = KIND_BYTES;
                o_cmd.rest       = {56'd0, i_uvalue[7:0]};
                o_cmd.max_bytes  = 4'd1;
            end
            FUNC_LE64: begin
                o_cmd.kind       = KIND_BYTES;
                o_cmd.rest       = i_uvalue;
                o_cmd.max_bytes  = 4'd8;
            end
            default: begin
                // unused codes produce nothing
                o_cmd_used = 1'b0;
            end
        endcase
    end

endmodule

>>> src/vrfe_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrfe_cmd_fifo
// Short command queue decoupling the classifier from the byte emitter.
// ----------------------------------------------------------------------------
module vrfe_cmd_fifo
    import vrfe_pkg::*;
#(
    parameter int DEPTH = CMD_FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == DEPTH_C);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("command queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full command queue");

endmodule

>>> src/vrfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrfe_back
// Byte emitter: walks one command, one output byte per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module vrfe_back
    import vrfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    vrfe_out_if.source  o_out
);

    logic                r_busy;
    t_kind               r_kind;
    logic [GROUP_W-1:0]  r_b;
    logic [UVALUE_W-1:0] r_rest;
    logic [COUNT_W-1:0]  r_k;
    logic [COUNT_W-1:0]  r_max;
    logic [FMASK_W-1:0]  r_mask;
    logic                r_fin;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_last;

    logic                out_free;
    logic                step;
    logic                step_last;
    logic [BYTE_W-1:0]   step_byte;
    logic                load;
    logic [GROUP_W-1:0]  n_b;
    logic [UVALUE_W-1:0] n_rest;
    logic [COUNT_W-1:0]  n_k;
    logic                n_fin;

    assign out_free  = !r_out_valid || o_out.ready;
    assign step      = r_busy && out_free;
    assign load      = i_cmd_valid && (!r_busy || (step && step_last));
    assign o_cmd_pop = load;

    always_comb begin
        step_byte = '0;
        step_last = 1'b0;
        n_b       = r_b;
        n_rest    = r_rest;
        n_k       = r_k + 1'b1;
        n_fin     = r_fin;
        unique case (r_kind)
            KIND_BYTES: begin
                step_byte = r_rest[BYTE_W-1:0];
                step_last = (n_k == r_max);
                n_rest    = r_rest >> BYTE_W;
            end
            KIND_GROUP: begin
                if (r_fin) begin
                    step_byte = {3'd0, r_rest[FMASK_W-1:0] & r_mask};
                    step_last = 1'b1;
                end else if (r_rest == '0) begin
                    step_byte = {1'b0, r_b};
                    step_last = 1'b1;
                end else begin
                    step_byte = CONT_BIT | {1'b0, r_b};
                    // the byte at the final position takes what is left, masked
                    if (n_k == r_max - 1'b1) begin
                        n_fin = 1'b1;
                    end else begin
                        n_b    = r_rest[GROUP_W-1:0];
                        n_rest = r_rest >> GROUP_W;
                    end
                end
            end
            default: begin
                step_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= i_cmd.kind;
            r_b    <= i_cmd.first;
            r_rest <= i_cmd.rest;
            r_max  <= i_cmd.max_bytes;
            r_mask <= i_cmd.final_mask;
            r_k    <= '0;
            r_fin  <= 1'b0;
        end else if (step) begin
            r_b    <= n_b;
            r_rest <= n_rest;
            r_k    <= n_k;
            r_fin  <= n_fin;
        end
        if (step) begin
            r_out_byte <= step_byte;
            r_out_last <= step_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (step && step_last) begin
                r_busy <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.last_byte = r_out_last;

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_k < r_max))
        else $error("byte index past item length");

    a_fin_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_fin) |-> step_last)
        else $error("final group byte not flagged last");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_busy || step_last))
        else $error("command loaded over an unfinished item");

    a_step_drives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("emitted byte not presented");

endmodule

>>> src/varint_record_field_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_record_field_encoder
// Encodes one record field per item into varint, signed varint, raw or
// little-endian bytes, one output byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                         | handshake
//  i_in     | in  | func[2:0] uvalue[63:0] svalue   | valid/ready
//  o_out    | out | out_byte[7:0] last_byte         | valid/ready
//
//  An item produces 1 (raw), 8 (eight-byte), 1..5 (32-bit and signed)
//  or 1..10 (64-bit) output bytes.
//  Function codes 5..7 are accepted and produce no bytes.
//  Input is taken while the command queue has room, so items are accepted
//  back to back while the emitter works; bytes of consecutive items follow
//  without a gap. Output stalls hold the output register and back up the queue.
//  Reset is synchronous and clears the queue, emitter and output valid.
// ----------------------------------------------------------------------------
module varint_record_field_encoder
    import vrfe_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vrfe_in_if.sink    i_in,
    vrfe_out_if.source o_out
);

    logic cmd_used;
    t_cmd front_cmd;
    logic fifo_full;
    logic fifo_empty;
    t_cmd head_cmd;
    logic cmd_pop;

    vrfe_front u_front (
        .i_func     (i_in.func),
        .i_uvalue   (i_in.uvalue),
        .i_svalue   (i_in.svalue),
        .o_cmd_used (cmd_used),
        .o_cmd      (front_cmd)
    );

    assign i_in.ready = !fifo_full;

    vrfe_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_in.valid && !fifo_full && cmd_used),
        .i_push_cmd (front_cmd),
        .o_full     (fifo_full),
        .i_pop      (cmd_pop),
        .o_empty    (fifo_empty),
        .o_head     (head_cmd)
    );

    vrfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!fifo_empty),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

endmodule

>>> tb/sv/vrfe_byte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrfe_byte_checker
// Watches the item and byte channels of the varint record field encoder,
// computes the byte stream that each accepted item must produce and compares
// every accepted output byte, in order, against it.
// ----------------------------------------------------------------------------
module vrfe_byte_checker
    import vrfe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    vrfe_in_if   i_in,
    vrfe_out_if  i_out,
    output int   o_pending,
    output int   o_fail_count
);

    localparam logic [7:0] GROUP_MASK    = 8'h7f;
    localparam int         U32_MAX_BYTES = 5;
    localparam int         U64_MAX_BYTES = 10;
    localparam int         S32_MAX_BYTES = 5;
    localparam logic [7:0] U32_TOP_MASK  = 8'h0f;
    localparam logic [7:0] U64_TOP_MASK  = 8'h01;
    localparam logic [7:0] S32_TOP_MASK  = 8'h1f;
    localparam int         LE64_BYTES    = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_enc_byte;

    t_enc_byte expected_bytes[$];
    int        fails = 0;

    function automatic void push_byte(logic [7:0] data, logic last);
        t_enc_byte eb;
        eb.data = data;
        eb.last = last;
        expected_bytes.push_back(eb);
    endfunction

    // 7-bit groups, low first; the byte at position max_bytes-1 is cut by top_mask
    function automatic void push_groups(logic [7:0] first, logic [63:0] rest,
                                        int max_bytes, logic [7:0] top_mask);
        int         count;
        logic [7:0] cur;
        count = 0;
        cur   = first;
        while (1'b1) begin
            if (rest == 64'd0) begin
                push_byte(cur, 1'b1);
                return;
            end
            push_byte(cur | CONT_BIT, 1'b0);
            count++;
            if (count == max_bytes - 1) begin
                push_byte(rest[7:0] & top_mask, 1'b1);
                return;
            end
            cur  = rest[7:0] & GROUP_MASK;
            rest = rest >> GROUP_W;
        end
    endfunction

    function automatic void encode_field(logic [FUNC_W-1:0] func,
                                         logic [UVALUE_W-1:0] uv,
                                         logic signed [SVALUE_W-1:0] sv);
        logic        neg;
        logic [31:0] mag;
        case (func)
            FUNC_U32: push_groups({1'b0, uv[6:0]}, {39'd0, uv[31:7]},
                                  U32_MAX_BYTES, U32_TOP_MASK);
            FUNC_U64: push_groups({1'b0, uv[6:0]}, {7'd0, uv[63:7]},
                                  U64_MAX_BYTES, U64_TOP_MASK);
            FUNC_S32: begin
                // sign in bit 0, six magnitude bits above it
                neg = sv[31];
                mag = neg ? (~sv + 32'd1) : sv;
                push_groups({1'b0, mag[5:0], neg}, {38'd0, mag[31:6]},
                            S32_MAX_BYTES, S32_TOP_MASK);
            end
            FUNC_RAW: push_byte(uv[7:0], 1'b1);
            FUNC_LE64: begin
                for (int i = 0; i < LE64_BYTES; i++) begin
                    push_byte(uv[8*i +: 8], i == LE64_BYTES - 1);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_enc_byte want;
        if (i_rst_n) begin
            if (i_out.valid && i_out.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected byte: out_byte actual %02h, last_byte actual %0b",
                           i_out.out_byte, i_out.last_byte);
                    fails++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out.out_byte !== want.data) begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.data, i_out.out_byte);
                        fails++;
                    end
                    if (i_out.last_byte !== want.last) begin
                        $error("last_byte mismatch: expected %0b, actual %0b",
                               want.last, i_out.last_byte);
                        fails++;
                    end
                end
            end
            // an item taken at this edge cannot have bytes out at the same edge
            if (i_in.valid && i_in.ready) begin
                encode_field(i_in.func, i_in.uvalue, i_in.svalue);
            end
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= fails;
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed items, then random bursts of field items, into the varint
// record field encoder, stalls the byte output on its own pattern and reports
// the verdict of the byte checker.
// ----------------------------------------------------------------------------
module tb_top;
    import vrfe_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 380;
    localparam int LONG_HOLD      = 200;
    localparam int HOLD_AT_ITEM   = 120;
    localparam int PAUSE_AT_ITEM  = 250;
    localparam int END_TAIL       = 40;
    localparam int TIMEOUT_NS     = 4_000_000;
    localparam int MAX_STRING_LEN = 12;
    localparam int FUNC_UNUSED_LO = 5;
    localparam int FUNC_UNUSED_HI = 7;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   pending;
    int   fail_count;
    int   random_items = 0;
    int   burst_left = 0;
    bit   hold_off_go = 1'b0;
    bit   hold_done = 1'b0;
    bit   paused_once = 1'b0;
    int   run_len;
    int   stall_len;

    vrfe_in_if  in_if();
    vrfe_out_if out_if();

    varint_record_field_encoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    vrfe_byte_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_if),
        .i_out        (out_if),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // value with a random number of significant bits
    function automatic logic [63:0] rand_u64();
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    function automatic logic [31:0] rand_s32();
        logic [31:0] v;
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    task automatic send_item(logic [FUNC_W-1:0] func, logic [63:0] uv, logic [31:0] sv);
        @(negedge i_clk);
        in_if.valid  <= 1'b1;
        in_if.func   <= func;
        in_if.uvalue <= uv;
        in_if.svalue <= sv;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic hold_valid_low(int cycles);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            hold_valid_low($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send_random(logic [FUNC_W-1:0] func);
        send_item(func, rand_u64(), rand_s32());
        random_items++;
        pace();
    endtask

    // receiver: ready runs and stalls, one long hold-off when asked
    initial begin
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_go && !hold_done) begin
                hold_done = 1'b1;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    out_if.ready <= 1'b0;
                end
            end else begin
                run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 12);
                stall_len = $urandom_range(0, 5);
                repeat (run_len) begin
                    @(negedge i_clk);
                    out_if.ready <= 1'b1;
                end
                repeat (stall_len) begin
                    @(negedge i_clk);
                    out_if.ready <= 1'b0;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int str_len;
        int pick;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.func   = FUNC_U32;
        in_if.uvalue = 64'd0;
        in_if.svalue = 32'sd0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed: group boundaries, full widths, sign cases, raw and pattern
        send_item(FUNC_U32, 64'd0, 32'd0);
        send_item(FUNC_U32, 64'd127, 32'd0);
        send_item(FUNC_U32, 64'd128, 32'd0);
        send_item(FUNC_U32, 64'hdead_beef_1000_0000, 32'd0);
        send_item(FUNC_U32, 64'h0000_0000_ffff_ffff, 32'd0);
        send_item(FUNC_U64, 64'd0, 32'd0);
        send_item(FUNC_U64, 64'h7fff_ffff_ffff_ffff, 32'd0);
        send_item(FUNC_U64, 64'h8000_0000_0000_0000, 32'd0);
        send_item(FUNC_U64, 64'hffff_ffff_ffff_ffff, 32'd0);
        send_item(FUNC_S32, 64'd0, 32'd0);
        send_item(FUNC_S32, 64'd0, 32'hffff_ffff);
        send_item(FUNC_S32, 64'd0, 32'd63);
        send_item(FUNC_S32, 64'd0, -32'sd64);
        send_item(FUNC_S32, 64'd0, 32'h7fff_ffff);
        send_item(FUNC_S32, 64'd0, 32'h8000_0001);
        // most negative value keeps its full magnitude
        send_item(FUNC_S32, 64'd0, 32'h8000_0000);
        send_item(FUNC_RAW, 64'hffff_ffff_ffff_ff00, 32'd0);
        send_item(FUNC_RAW, 64'd255, 32'd0);
        send_item(FUNC_LE64, 64'h0123_4567_89ab_cdef, 32'd0);
        send_item(FUNC_LE64, 64'hffff_ffff_ffff_ffff, 32'd0);
        for (int f = FUNC_UNUSED_LO; f <= FUNC_UNUSED_HI; f++) begin
            send_item(f[FUNC_W-1:0], 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
        end
        hold_valid_low(1);
        wait (pending == 0);

        while (random_items < RANDOM_ITEMS) begin
            if (!hold_off_go && random_items >= HOLD_AT_ITEM) hold_off_go = 1'b1;
            if (!paused_once && random_items >= PAUSE_AT_ITEM) begin
                paused_once = 1'b1;
                hold_valid_low(1);
                wait (pending == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                // string: length then that many raw bytes
                str_len = $urandom_range(0, MAX_STRING_LEN);
                send_item(FUNC_U32, {$urandom, 32'(str_len)}, rand_s32());
                random_items++;
                pace();
                repeat (str_len) send_random(FUNC_RAW);
            end else if (pick < 21) begin
                send_random(FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI)));
            end else begin
                send_random(FUNC_W'($urandom_range(FUNC_U32, FUNC_LE64)));
            end
        end
        hold_valid_low(1);

        wait (pending == 0);
        repeat (END_TAIL) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
